// ===== sv/maps_line_range_finder_assert.svh =====
// assertion macros for the maps line range finder
// no dependencies; taken in by the top level
`ifndef MAPS_LINE_RANGE_FINDER_ASSERT_SVH
`define MAPS_LINE_RANGE_FINDER_ASSERT_SVH

// same-cycle implication under reset
`define LRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrf assertion failed");

// next-cycle implication under reset
`define LRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrf assertion failed");

`endif

// ===== sv/lrf_pkg.sv =====
// shared widths, character codes and beat types for the range finder
// no dependencies
package lrf_pkg;

	localparam int ADDR_W     = 64;
	localparam int LEN_W      = 13;
	localparam int LINE_LIMIT = 4096;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_A       = 8'h61;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [3:0] ALPHA_BIAS = 4'd9;

	// one registered text beat
	typedef struct packed {
		logic       valid;
		logic [7:0] text_byte;
		logic       end_of_stream;
	} beat_t;

	// one result beat payload
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] range_low;
		logic [ADDR_W-1:0] range_high;
	} result_t;

endpackage

// ===== sv/lrf_ifs.sv =====
// valid/ready channel interfaces for text bytes and results
// depends on lrf_pkg for widths

interface lrf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_stream;

	modport source (output valid, output text_byte, output end_of_stream, input ready);
	modport sink   (input valid, input text_byte, input end_of_stream, output ready);
endinterface

interface lrf_result_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [lrf_pkg::ADDR_W-1:0] range_low;
	logic [lrf_pkg::ADDR_W-1:0] range_high;

	modport source (output valid, output found, output range_low, output range_high,
		input ready);
	modport sink   (input valid, input found, input range_low, input range_high,
		output ready);
endinterface

// ===== sv/lrf_in_stage.sv =====
// input register stage: holds one text beat until the parser takes it
// depends on lrf_pkg and lrf_byte_if
module lrf_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	lrf_byte_if.sink       text,
	input  logic           advance,
	output lrf_pkg::beat_t beat
);
	import lrf_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// free when empty or when the held beat moves on
	assign text.ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			eos_s1  <= text.end_of_stream;
		end
	end

	assign beat = '{valid: valid_s1, text_byte: byte_s1, end_of_stream: eos_s1};

endmodule

// ===== sv/lrf_parser.sv =====
// line parser: hex accumulators, line length and match decision per byte
// depends on lrf_pkg
module lrf_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lrf_pkg::beat_t             beat,
	input  logic [lrf_pkg::ADDR_W-1:0] search_address,
	input  logic                       advance,
	output logic                       pending,
	output lrf_pkg::result_t           res
);
	import lrf_pkg::*;

	typedef enum logic [2:0] {
		PH_LOW  = 3'd0,
		PH_HIGH = 3'd1,
		PH_TAIL = 3'd2,
		PH_DEAD = 3'd3,
		PH_SKIP = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	phase_t            phase_q, u_phase, n_phase, d_phase;
	logic [ADDR_W-1:0] low_q, high_q, u_low, u_high, n_low, n_high, d_low, d_high;
	logic [LEN_W-1:0]  len_q, u_len, n_len;
	logic              is_nl, is_num, is_alpha, is_digit, at_limit, decide_ok, hit;
	logic [3:0]        digit;

	// character classes
	always_comb begin
		is_nl    = (beat.text_byte == CH_NEWLINE);
		is_num   = (beat.text_byte >= CH_ZERO) && (beat.text_byte <= CH_NINE);
		is_alpha = (beat.text_byte >= CH_A) && (beat.text_byte <= CH_F);
		is_digit = is_num || is_alpha;
		digit    = is_num ? beat.text_byte[3:0] : beat.text_byte[3:0] + ALPHA_BIAS;
	end

	// field update for a non-newline byte
	always_comb begin
		u_phase = phase_q;
		u_low   = low_q;
		u_high  = high_q;
		unique case (phase_q)
			PH_LOW: begin
				if (is_digit) u_low = {low_q[ADDR_W-5:0], digit};
				else if (beat.text_byte == CH_DASH) u_phase = PH_HIGH;
				else u_phase = PH_DEAD;
			end
			PH_HIGH: begin
				if (is_digit) u_high = {high_q[ADDR_W-5:0], digit};
				else u_phase = PH_TAIL;
			end
			default: ;
		endcase
		u_len    = len_q + LEN_W'(1);
		at_limit = ({1'b0, u_len} >= (LEN_W+1)'(LINE_LIMIT));
	end

	// decision on current fields at a newline, on updated ones at the limit
	always_comb begin
		d_phase   = is_nl ? phase_q : u_phase;
		d_low     = is_nl ? low_q : u_low;
		d_high    = is_nl ? high_q : u_high;
		decide_ok = ((d_phase == PH_HIGH) || (d_phase == PH_TAIL)) &&
			(d_low < d_high) && (search_address >= d_low) && (search_address < d_high);
	end

	// next state and result
	always_comb begin
		n_phase = phase_q;
		n_low   = low_q;
		n_high  = high_q;
		n_len   = len_q;
		hit     = 1'b0;
		if (phase_q == PH_DONE) begin
			// bytes after a match are ignored
		end else if (is_nl) begin
			if (phase_q != PH_SKIP && decide_ok) begin
				hit     = 1'b1;
				n_phase = PH_DONE;
			end else begin
				n_phase = PH_LOW;
				n_low   = '0;
				n_high  = '0;
				n_len   = '0;
			end
		end else if (phase_q != PH_SKIP) begin
			n_phase = u_phase;
			n_low   = u_low;
			n_high  = u_high;
			n_len   = u_len;
			if (at_limit) begin
				if (decide_ok) begin
					hit     = 1'b1;
					n_phase = PH_DONE;
				end else begin
					n_phase = PH_SKIP;
				end
			end
		end
		pending = hit || (beat.end_of_stream && n_phase != PH_DONE);
		res.found      = hit;
		res.range_low  = hit ? d_low : '0;
		res.range_high = hit ? d_high : '0;
		// end of stream clears everything
		if (beat.end_of_stream) begin
			n_phase = PH_LOW;
			n_low   = '0;
			n_high  = '0;
			n_len   = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOW;
			low_q   <= '0;
			high_q  <= '0;
			len_q   <= '0;
		end else if (advance) begin
			phase_q <= n_phase;
			low_q   <= n_low;
			high_q  <= n_high;
			len_q   <= n_len;
		end
	end

endmodule

// ===== sv/lrf_out_reg.sv =====
// result register driving the result channel
// depends on lrf_pkg and lrf_result_if
module lrf_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  lrf_pkg::result_t res,
	output logic             busy,
	lrf_result_if.source     result
);
	import lrf_pkg::*;

	logic    valid_q;
	result_t data_q;

	// held result not yet taken
	assign busy = valid_q && !result.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign result.valid      = valid_q;
	assign result.found      = data_q.found;
	assign result.range_low  = data_q.range_low;
	assign result.range_high = data_q.range_high;

endmodule

// ===== sv/maps_line_range_finder.sv =====
// path: an accepted byte is held in the input stage; any result it gives is loaded into the result register
// throughput: one text byte per cycle; a byte only waits while its own result
// cannot enter the result register because the previous one is still held
// reset: arst_n clears the parse state, search address and both valid flags
// depends on lrf_pkg, lrf_ifs, lrf_in_stage, lrf_parser, lrf_out_reg
module maps_line_range_finder (
	input  logic                       clk,
	input  logic                       arst_n,
	lrf_byte_if.sink                   text,
	lrf_result_if.source               result,
	input  logic                       cfg_wr_en,
	input  logic [lrf_pkg::ADDR_W-1:0] cfg_wr_data
);
	import lrf_pkg::*;

	`include "maps_line_range_finder_assert.svh"

	beat_t             beat;
	result_t           res;
	logic              pending, busy, advance;
	logic [ADDR_W-1:0] search_q;

	// search address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_q <= '0;
		end else if (cfg_wr_en) begin
			search_q <= cfg_wr_data;
		end
	end

	// a held byte moves on unless its result would hit a full register
	assign advance = beat.valid && !(pending && busy);

	lrf_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.advance (advance),
		.beat    (beat)
	);

	lrf_parser u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.beat           (beat),
		.search_address (search_q),
		.advance        (advance),
		.pending        (pending),
		.res            (res)
	);

	lrf_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && pending),
		.res    (res),
		.busy   (busy),
		.result (result)
	);

	// checks
	`LRF_ASSERT_NOW(a_notfound_zero, clk, arst_n, result.valid && !result.found, result.range_low == '0 && result.range_high == '0)
	`LRF_ASSERT_NOW(a_found_in_range, clk, arst_n, result.valid && result.found, result.range_low <= search_q && search_q < result.range_high)
	`LRF_ASSERT_NEXT(a_load_shows, clk, arst_n, advance && pending, result.valid)
	`LRF_ASSERT_NOW(a_stall_cause, clk, arst_n, beat.valid && !advance, result.valid && !result.ready)

endmodule

// ===== bench/maps_line_range_finder_test.sv =====
// testbench for the maps line range finder: sends text streams, predicts the
// found / not-found beat of each stream and checks result beats in order
// depends on lrf_pkg, lrf_ifs and the maps_line_range_finder rtl
module maps_line_range_finder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lrf_pkg::*;

	localparam int CYCLE_LIMIT    = 500000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_BEATS    = 165;
	localparam int PHASE_RESULTS  = 14;
	localparam int HEX_ALPHA_BASE = 10;
	localparam int RESET_CYCLES   = 7;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		SCAN_LOW, SCAN_HIGH, SCAN_TAIL, SCAN_DEAD, SCAN_SKIP, SCAN_DONE
	} scan_phase_t;

	// range predictor and store of expected result beats
	class range_scoreboard;
		logic [ADDR_W-1:0] address;
		scan_phase_t       scan_phase;
		logic [ADDR_W-1:0] low_acc;
		logic [ADDR_W-1:0] high_acc;
		logic [LEN_W-1:0]  line_len;
		result_t           expected_q[$];
		int                beats;
		int                predicted;
		int                errors;

		function new();
			address   = '0;
			beats     = 0;
			predicted = 0;
			errors    = 0;
			clear_line();
		endfunction

		function void clear_line();
			scan_phase = SCAN_LOW;
			low_acc    = '0;
			high_acc   = '0;
			line_len   = '0;
		endfunction

		function int digit_value(logic [7:0] ch);
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				return int'(ch - CH_ZERO);
			end
			if (ch >= CH_A && ch <= CH_F) begin
				return int'(ch - CH_A) + HEX_ALPHA_BASE;
			end
			return -1;
		endfunction

		// only a line with its dash seen can hold the address
		function bit range_hit();
			if (scan_phase != SCAN_HIGH && scan_phase != SCAN_TAIL) begin
				return 1'b0;
			end
			return low_acc < high_acc && address >= low_acc && address < high_acc;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// accepted text beat: advance the parse and queue any result
		function void note_beat(logic [7:0] ch, logic eos);
			result_t want;
			bit      emit;
			int      d;
			emit = 1'b0;
			want = '0;
			beats++;
			if (scan_phase == SCAN_DONE) begin
				// bytes after a match are ignored
			end else if (ch == CH_NEWLINE) begin
				if (scan_phase != SCAN_SKIP && range_hit()) begin
					want = '{found: 1'b1, range_low: low_acc, range_high: high_acc};
					emit = 1'b1;
					scan_phase = SCAN_DONE;
				end else begin
					clear_line();
				end
			end else if (scan_phase != SCAN_SKIP) begin
				d = digit_value(ch);
				if (scan_phase == SCAN_LOW) begin
					if (d >= 0) begin
						low_acc = {low_acc[ADDR_W-5:0], d[3:0]};
					end else if (ch == CH_DASH) begin
						scan_phase = SCAN_HIGH;
					end else begin
						scan_phase = SCAN_DEAD;
					end
				end else if (scan_phase == SCAN_HIGH) begin
					if (d >= 0) begin
						high_acc = {high_acc[ADDR_W-5:0], d[3:0]};
					end else begin
						scan_phase = SCAN_TAIL;
					end
				end
				line_len = line_len + 1'b1;
				// oversized line is decided on what has been read so far
				if (line_len >= LINE_LIMIT) begin
					if (range_hit()) begin
						want = '{found: 1'b1, range_low: low_acc, range_high: high_acc};
						emit = 1'b1;
						scan_phase = SCAN_DONE;
					end else begin
						scan_phase = SCAN_SKIP;
					end
				end
			end
			if (eos) begin
				if (!emit && scan_phase != SCAN_DONE) begin
					want = '0;
					emit = 1'b1;
				end
				clear_line();
			end
			if (emit) begin
				expected_q.push_back(want);
				predicted++;
			end
		endfunction

		// accepted result beat against the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: found %0d range_low %h range_high %h",
					got.found, got.range_low, got.range_high);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.range_low !== want.range_low) begin
				$error("range_low: expected %h, got %h", want.range_low, got.range_low);
				errors++;
			end
			if (got.range_high !== want.range_high) begin
				$error("range_high: expected %h, got %h", want.range_high, got.range_high);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [ADDR_W-1:0] cfg_wr_data;

	lrf_byte_if   text_ch ();
	lrf_result_if result_ch ();

	range_scoreboard sb;
	logic [7:0]      text_q[$];
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	bit              pressure_req = 1'b0;
	bit              pressure_done = 1'b0;
	int              cycle_count = 0;

	maps_line_range_finder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off when asked
	initial begin
		int held;
		held = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_req && !pressure_done) begin
				if (held < HOLD_CYCLES) begin
					result_ch.ready <= 1'b0;
					held++;
				end else begin
					pressure_done = 1'b1;
					result_ch.ready <= 1'b1;
				end
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			sb.check_result(result_t'{result_ch.found, result_ch.range_low,
				result_ch.range_high});
		end
	end

	function automatic logic [ADDR_W-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// random magnitude, small values often
	function automatic logic [ADDR_W-1:0] rand_span();
		return rand_word() >> $urandom_range(63);
	endfunction

	function automatic logic [7:0] rand_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(255));
		if (ch == CH_NEWLINE) begin
			ch = CH_SPACE;
		end
		return ch;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_ZERO + 8'(nib);
		end
		return CH_A + 8'(nib) - 8'(HEX_ALPHA_BASE);
	endfunction

	// range holding the current address where one exists
	function automatic void pick_containing(output logic [ADDR_W-1:0] lo,
		output logic [ADDR_W-1:0] hi);
		logic [ADDR_W-1:0] d;
		d  = ($urandom_range(7) == 0) ? '0 : rand_span();
		lo = (d > sb.address) ? '0 : sb.address - d;
		d  = ($urandom_range(7) == 0) ? '0 : rand_span();
		hi = sb.address + 64'd1 + d;
		if (sb.address == '1 || hi <= sb.address) begin
			hi = '1;
		end
	endfunction

	// mostly misses: random, reversed, exclusive top edge, just above
	function automatic void pick_other(output logic [ADDR_W-1:0] lo,
		output logic [ADDR_W-1:0] hi);
		logic [ADDR_W-1:0] d;
		case ($urandom_range(3))
			0: begin
				lo = rand_word();
				hi = rand_word();
			end
			1: begin
				pick_containing(hi, lo);
			end
			2: begin
				d  = rand_span();
				lo = (d > sb.address) ? '0 : sb.address - d;
				hi = sb.address;
			end
			default: begin
				lo = sb.address + 64'd1;
				hi = lo + rand_span();
			end
		endcase
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			text_q.push_back(s[i]);
		end
	endtask

	// hex field: empty for zero now and then, extra leading digits wrap out
	task automatic push_hex(input logic [ADDR_W-1:0] v);
		int n;
		n = 1;
		while (n < 16 && (v >> (4 * n)) != 0) begin
			n++;
		end
		if (v == '0 && $urandom_range(3) == 0) begin
			n = 0;
		end else if ($urandom_range(3) == 0) begin
			n += $urandom_range(1, 3);
		end
		for (int i = n - 1; i >= 0; i--) begin
			text_q.push_back(hex_char(i < 16 ? v[i*4 +: 4] : 4'($urandom_range(15))));
		end
	endtask

	task automatic push_range(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
		push_hex(lo);
		text_q.push_back(CH_DASH);
		push_hex(hi);
	endtask

	// one newline-ended line: half well-formed ranges, the rest broken or empty
	task automatic add_line();
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		int                kind;
		kind = $urandom_range(9);
		if (kind <= 4) begin
			if ($urandom_range(2) == 0) begin
				pick_containing(lo, hi);
			end else begin
				pick_other(lo, hi);
			end
			push_range(lo, hi);
			if ($urandom_range(1)) begin
				text_q.push_back(CH_SPACE);
				repeat ($urandom_range(8)) text_q.push_back(rand_char());
			end
		end else begin
			case (kind)
				5: repeat ($urandom_range(1, 12)) text_q.push_back(rand_char());
				6: begin
					push_hex(rand_span());
					if ($urandom_range(1)) begin
						text_q.push_back(rand_char());
					end
				end
				7: begin
					push_hex(rand_span());
					text_q.push_back(CH_DASH);
				end
				8: begin
					pick_containing(lo, hi);
					text_q.push_back(CH_DASH);
					push_hex(hi);
				end
				default: ;
			endcase
		end
		text_q.push_back(CH_NEWLINE);
	endtask

	// short stream, sometimes ending on an unterminated line or junk
	task automatic build_stream();
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		repeat ($urandom_range(1, 4)) add_line();
		if ($urandom_range(4) == 0) begin
			pick_containing(lo, hi);
			push_range(lo, hi);
		end
		if ($urandom_range(6) == 0) begin
			repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(255)));
		end
	endtask

	// lines at and around the length limit
	task automatic build_oversized(input int kind);
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		pick_containing(lo, hi);
		case (kind)
			0: begin
				// decided at the limit byte, rest ignored after the match
				push_range(lo, hi);
				text_q.push_back(CH_SPACE);
				while (text_q.size() < LINE_LIMIT) text_q.push_back(rand_char());
				push_text("\n1-2\n");
			end
			1: begin
				// one byte short of the limit, decided at its newline
				push_range(lo, hi);
				text_q.push_back(CH_SPACE);
				while (text_q.size() < LINE_LIMIT - 1) text_q.push_back(rand_char());
				text_q.push_back(CH_NEWLINE);
			end
			default: begin
				// digits only past the limit, then a skipped dash and range
				while (text_q.size() < LINE_LIMIT + 4) begin
					text_q.push_back(hex_char(4'($urandom_range(15))));
				end
				text_q.push_back(CH_DASH);
				push_hex(hi);
				text_q.push_back(CH_NEWLINE);
				push_range(lo, hi);
				text_q.push_back(CH_NEWLINE);
			end
		endcase
	endtask

	// one text beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [7:0] ch, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid         <= 1'b1;
		text_ch.text_byte     <= ch;
		text_ch.end_of_stream <= eos;
		@(posedge clk);
		while (!text_ch.ready) begin
			@(posedge clk);
		end
		sb.note_beat(ch, eos);
	endtask

	// whole queued stream, end marked on its last byte
	task automatic send_stream();
		for (int i = 0; i < text_q.size(); i++) begin
			send_beat(text_q[i], i == text_q.size() - 1);
		end
		text_q.delete();
	endtask

	// wait until every expected result is in and the pipeline is empty
	task automatic settle();
		text_ch.valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(input logic [ADDR_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.address = value;
	endtask

	// main sequence
	initial begin
		int first_beat;
		int first_result;
		sb = new();
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		text_ch.valid         = 1'b0;
		text_ch.text_byte     = '0;
		text_ch.end_of_stream = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty low, end on a matching newline
		write_address(64'd3);
		push_text("-5\n");
		send_stream();
		// empty high, no dash, unterminated final line
		push_text("3-\n2\n1-4");
		send_stream();
		// byte extremes in the tail, bytes after a match
		push_text("1-9 ");
		text_q.push_back(8'hFF);
		push_text("\n");
		text_q.push_back(8'h00);
		send_stream();
		// upper case is not hex
		push_text("A-f\nx");
		send_stream();

		// random streams under each idling pattern
		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: write_address('0);
				1: write_address('1);
				default: write_address(rand_word());
			endcase
			send_idle_pct  = (p == 1) ? 77 : (p == 3) ? 28 : 0;
			recv_stall_pct = (p == 2) ? 77 : (p == 3) ? 28 : 0;
			first_beat   = sb.beats;
			first_result = sb.predicted;
			while (sb.beats - first_beat < PHASE_BEATS ||
				sb.predicted - first_result < PHASE_RESULTS) begin
				build_stream();
				send_stream();
			end
		end

		// long result hold-off with the sender pushing on
		settle();
		write_address(rand_word());
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pressure_req   = 1'b1;
		repeat (12) begin
			build_stream();
			send_stream();
		end
		while (!pressure_done) begin
			@(posedge clk);
		end

		// oversized lines
		settle();
		write_address(rand_word());
		send_idle_pct  = 28;
		recv_stall_pct = 28;
		for (int k = 0; k < 3; k++) begin
			build_oversized(k);
			send_stream();
		end

		settle();
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lrf_pkg.sv
sv/lrf_ifs.sv
sv/lrf_in_stage.sv
sv/lrf_parser.sv
sv/lrf_out_reg.sv
sv/maps_line_range_finder.sv
bench/maps_line_range_finder_test.sv
